// ----- hw/rtl/twhb_pkg.sv -----
// ----------------------------------------------------------------------------
// Time window history buffer package
// Sizes, mode codes, window lengths and helpers shared by the buffer and its checker.
// ----------------------------------------------------------------------------
package twhb_pkg;

    localparam int CAPACITY       = 2048;
    localparam int SNAPSHOT_LIMIT = 32;
    localparam int ADDR_W         = $clog2(CAPACITY);
    localparam int FILL_W         = $clog2(CAPACITY + 1);
    localparam int COUNT_W        = 12;
    localparam int COUNT_MAX      = 4095;
    localparam int WORD_W         = 32;
    localparam int TIME_W         = 64;
    localparam int ENTRY_W        = 64;

    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_EXPORT = 2'd2;

    localparam logic [1:0] RANGE_HOUR = 2'd0;
    localparam logic [1:0] RANGE_DAY  = 2'd1;
    localparam logic [1:0] RANGE_WEEK = 2'd2;

    localparam logic [TIME_W-1:0] MS_HOUR = 64'd3600000;
    localparam logic [TIME_W-1:0] MS_DAY  = 64'd86400000;
    localparam logic [TIME_W-1:0] MS_WEEK = 64'd604800000;

    function automatic logic [TIME_W-1:0] window_length(input logic [1:0] code);
        logic [TIME_W-1:0] len;
        case (code)
            RANGE_DAY:  len = MS_DAY;
            RANGE_WEEK: len = MS_WEEK;
            default:    len = MS_HOUR;
        endcase
        return len;
    endfunction

    function automatic logic [COUNT_W-1:0] clip_count(input logic [FILL_W-1:0] n);
        logic [31:0] wide;
        wide = 32'(n);
        return (wide > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : wide[COUNT_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/twhb_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module twhb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/time_window_history_buffer.sv -----
// ----------------------------------------------------------------------------
// Time window history buffer
// Circular store of timestamped samples with windowed snapshot and count.
//
//   Channel   Handshake                 Payload
//   command   start / busy              mode, time_ms, window_range, words
//   result    result_valid (strobe)     has_sample, sample_*, match_count,
//                                       last_of_run
// A push is written in the cycle it is accepted and busy stays low.
// A snapshot query scans back from the newest sample over at most min(fill,
// SNAPSHOT_LIMIT) samples, stopping at one outside the window, has a setup
// state, then gives one result per cycle; an export count scans all fill
// samples. The single read port of the stores sets this pace.
// Reset clears the state, write pointer, fill level, check flag and strobe.
// The receiver cannot stall; each result strobes for one cycle.
// ----------------------------------------------------------------------------
module time_window_history_buffer
    import twhb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          mode,
    input  logic [TIME_W-1:0]   time_ms,
    input  logic [1:0]          window_range,
    input  logic [WORD_W-1:0]   voltage_word,
    input  logic [WORD_W-1:0]   current_word,
    input  logic [WORD_W-1:0]   temperature_word,
    input  logic [WORD_W-1:0]   charge_word,
    output logic                result_valid,
    output logic                has_sample,
    output logic [TIME_W-1:0]   sample_time,
    output logic [WORD_W-1:0]   sample_voltage,
    output logic [WORD_W-1:0]   sample_current,
    output logic [WORD_W-1:0]   sample_temperature,
    output logic [WORD_W-1:0]   sample_charge,
    output logic [COUNT_W-1:0]  match_count,
    output logic                last_of_run
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_PREP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(CAPACITY - 1);

    logic [1:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  wp_reg, wp_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0]  ptr_reg, ptr_next;
    logic [FILL_W-1:0]  cnt_reg, cnt_next;
    logic [FILL_W-1:0]  lim_reg, lim_next;
    logic [FILL_W-1:0]  got_reg, got_next;
    logic               chk_reg, chk_next;
    logic               export_reg, export_next;
    logic [TIME_W-1:0]  cut_reg, cut_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_has_reg, out_has_next;
    logic               out_last_reg, out_last_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    logic               accept;
    logic               push;
    logic [TIME_W-1:0]  len;
    logic [ADDR_W-1:0]  raddr;
    logic [ENTRY_W-1:0] time_rd, elec_rd, therm_rd;
    logic               issuing;
    logic               match;
    logic [FILL_W-1:0]  got_inc;
    logic               stop;

    assign accept = start && !busy;
    assign push   = accept && (mode == MODE_PUSH);
    assign len    = window_length(window_range);
    assign raddr  = ptr_reg;

    twhb_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_time_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wp_reg),
        .wdata (time_ms),
        .raddr (raddr),
        .rdata (time_rd)
    );

    twhb_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_elec_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wp_reg),
        .wdata ({voltage_word, current_word}),
        .raddr (raddr),
        .rdata (elec_rd)
    );

    twhb_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_therm_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wp_reg),
        .wdata ({temperature_word, charge_word}),
        .raddr (raddr),
        .rdata (therm_rd)
    );

    assign issuing = (cnt_reg < lim_reg);
    assign match   = chk_reg && (time_rd >= cut_reg);
    assign got_inc = got_reg + FILL_W'(match);

    always_comb
    begin
        if (export_reg)
        begin
            stop = !chk_reg && !issuing;
        end
        else
        begin
            stop = (chk_reg && !match)
                || (match && (32'(got_reg) + 32'd1 == 32'(SNAPSHOT_LIMIT)))
                || (!chk_reg && !issuing);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        lim_next       = lim_reg;
        got_next       = got_reg;
        chk_next       = 1'b0;
        export_next    = export_reg;
        cut_next       = cut_reg;
        out_valid_next = 1'b0;
        out_has_next   = 1'b0;
        out_last_next  = 1'b0;
        out_count_next = out_count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (push)
                begin
                    wp_next = (wp_reg == LAST_SLOT) ? '0 : wp_reg + ADDR_W'(1);
                    if (32'(fill_reg) < 32'(CAPACITY))
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                else if (accept && (mode == MODE_QUERY || mode == MODE_EXPORT))
                begin
                    state_next  = ST_SCAN;
                    export_next = (mode == MODE_EXPORT);
                    cut_next    = (time_ms >= len) ? (time_ms - len) : '0;
                    ptr_next    = (wp_reg == '0) ? LAST_SLOT : wp_reg - ADDR_W'(1);
                    cnt_next    = '0;
                    got_next    = '0;
                    if (mode == MODE_QUERY && 32'(fill_reg) > 32'(SNAPSHOT_LIMIT))
                    begin
                        lim_next = FILL_W'(SNAPSHOT_LIMIT);
                    end
                    else
                    begin
                        lim_next = fill_reg;
                    end
                end
            end

            ST_SCAN:
            begin
                got_next = got_inc;
                if (stop)
                begin
                    state_next = ST_PREP;
                end
                else if (issuing)
                begin
                    chk_next = 1'b1;
                    cnt_next = cnt_reg + FILL_W'(1);
                    ptr_next = (ptr_reg == '0) ? LAST_SLOT : ptr_reg - ADDR_W'(1);
                end
            end

            ST_PREP:
            begin
                out_count_next = clip_count(got_reg);
                if (export_reg || got_reg == '0)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                    cnt_next   = '0;
                    if (32'(wp_reg) >= 32'(got_reg))
                    begin
                        ptr_next = ADDR_W'(32'(wp_reg) - 32'(got_reg));
                    end
                    else
                    begin
                        ptr_next = ADDR_W'(32'(wp_reg) + 32'(CAPACITY) - 32'(got_reg));
                    end
                end
            end

            ST_EMIT:
            begin
                out_valid_next = 1'b1;
                out_has_next   = 1'b1;
                cnt_next       = cnt_reg + FILL_W'(1);
                ptr_next       = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + ADDR_W'(1);
                if (cnt_reg + FILL_W'(1) == got_reg)
                begin
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            chk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            chk_reg       <= chk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        cnt_reg       <= cnt_next;
        lim_reg       <= lim_next;
        got_reg       <= got_next;
        export_reg    <= export_next;
        cut_reg       <= cut_next;
        out_has_reg   <= out_has_next;
        out_last_reg  <= out_last_next;
        out_count_reg <= out_count_next;
    end

    assign busy               = (state_reg != ST_IDLE);
    assign result_valid       = out_valid_reg;
    assign has_sample         = out_has_reg;
    assign last_of_run        = out_last_reg;
    assign match_count        = out_count_reg;
    assign sample_time        = out_has_reg ? time_rd : '0;
    assign sample_voltage     = out_has_reg ? elec_rd[ENTRY_W-1:WORD_W] : '0;
    assign sample_current     = out_has_reg ? elec_rd[WORD_W-1:0] : '0;
    assign sample_temperature = out_has_reg ? therm_rd[ENTRY_W-1:WORD_W] : '0;
    assign sample_charge      = out_has_reg ? therm_rd[WORD_W-1:0] : '0;

endmodule

// ----- hw/rtl/twhb_checker.sv -----
// ----------------------------------------------------------------------------
// Time window history buffer checker
// Port-level properties of the command and result transfers.
// ----------------------------------------------------------------------------
module twhb_checker
    import twhb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [1:0]          mode,
    input  logic                result_valid,
    input  logic                has_sample,
    input  logic [TIME_W-1:0]   sample_time,
    input  logic                last_of_run
);

    a_push_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && mode == MODE_PUSH |=> !busy)
        else $error("push transfer made the block busy");

    a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (mode == MODE_QUERY || mode == MODE_EXPORT) |=> busy)
        else $error("query transfer did not start a scan");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !has_sample |-> last_of_run && sample_time == '0)
        else $error("empty result is not a clean final result");

    a_run_is_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_of_run |=> result_valid && has_sample)
        else $error("result run broken before its final transfer");

endmodule

bind time_window_history_buffer twhb_checker u_twhb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .result_valid (result_valid),
    .has_sample   (has_sample),
    .sample_time  (sample_time),
    .last_of_run  (last_of_run)
);
